// ----- hw/rtl/modular_exponentiation_macros.svh -----
// ============================================================================
// Assertion macros for the modular exponentiation block.
// Checks compile in simulation only and vanish when SYNTHESIS is defined.
// ============================================================================
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is ignored while reset is asserted.
`define MEXP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("modular exponentiation assertion failed");
// Clocked check that also holds during reset.
`define MEXP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("modular exponentiation assertion failed");
`else
`define MEXP_ASSERT(lbl, prop)
`define MEXP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hw/rtl/mexp_pkg.sv -----
// ============================================================================
// mexp_pkg
// Shared types and constants of the modular exponentiation block.
// ============================================================================
package mexp_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam logic [63:0] EXP_RESET = 64'd65537;

    // Configuration register indexes.
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_LOAD,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    // Which candidate a cell keeps: 2r+a, 2r+a-m or 2r+a-2m.
    typedef enum logic [1:0] {
        SEL_SUM,
        SEL_SUB1,
        SEL_SUB2
    } t_sel;

    // Carry and borrows rippling from one cell to the next.
    typedef struct packed {
        logic c;
        logic bw1;
        logic bw2;
    } t_chain;

endpackage

// ----- hw/rtl/modular_exponentiation.sv -----
// ============================================================================
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ============================================================================
// One base is processed at a time. The base is first reduced, then each
// exponent bit up to the highest set one costs a multiply step and an update
// step, because two rows of bit cells run the multiply and the square side
// by side at one multiplier bit per cycle. A modulus of 0 or 1 skips the
// reduction and the multiply steps and goes straight to the result. A
// finished result waits in the output register while the next base is
// taken.
module modular_exponentiation import mexp_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_base_valid,
    output logic        o_base_stall,
    input  logic [63:0] i_base,
    output logic        o_power_valid,
    input  logic        i_power_stall,
    output logic [63:0] o_power,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

`include "modular_exponentiation_macros.svh"

    localparam int CW = $clog2(WORD_BITS);

    t_state               r_state;
    t_state               n_state;
    logic [WORD_BITS-1:0] r_mod_cfg;
    logic [WORD_BITS-1:0] r_exp_cfg;
    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_sq;
    logic [WORD_BITS-1:0] r_bsh;
    logic [CW-1:0]        r_cnt;
    logic [63:0]          r_out;
    logic                 r_out_valid;
    logic                 in_acc;
    logic                 out_free;
    logic                 row_clr;
    logic                 row_step_s;
    logic                 row_step_a;
    logic [WORD_BITS-1:0] a_s;
    logic [WORD_BITS-1:0] res_s;
    logic [WORD_BITS-1:0] res_a;
    logic [WORD_BITS-1:0] exp_next;

    assign o_cfg_ready   = 1'b1;
    assign o_base_stall  = (r_state != S_IDLE);
    assign o_power_valid = r_out_valid;
    assign o_power       = r_out;
    assign in_acc        = i_base_valid && !o_base_stall;
    assign out_free      = !r_out_valid || !i_power_stall;
    assign exp_next      = r_exp >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cfg <= WORD_BITS'(1);
            r_exp_cfg <= EXP_RESET[WORD_BITS-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODULUS:  r_mod_cfg <= i_cfg_data[WORD_BITS-1:0];
                CFG_EXPONENT: r_exp_cfg <= i_cfg_data[WORD_BITS-1:0];
                default:      r_mod_cfg <= r_mod_cfg;
            endcase
        end
    end

    // The square row also reduces the base: with a = 1 it runs Horner's rule.
    assign a_s        = (r_state == S_RED) ? WORD_BITS'(1) : r_sq;
    assign row_step_s = (r_state == S_RED) || (r_state == S_MUL);
    assign row_step_a = (r_state == S_MUL);
    assign row_clr    = in_acc || (r_state == S_LOAD) || (r_state == S_UPD);

    mexp_row #(.WORD_BITS(WORD_BITS)) u_row_sq (
        .i_clk  (i_clk),
        .i_clr  (row_clr),
        .i_step (row_step_s),
        .i_a    (a_s),
        .i_b    (r_bsh[WORD_BITS-1]),
        .i_m    (r_mod),
        .o_r    (res_s)
    );

    mexp_row #(.WORD_BITS(WORD_BITS)) u_row_acc (
        .i_clk  (i_clk),
        .i_clr  (row_clr),
        .i_step (row_step_a),
        .i_a    (r_acc),
        .i_b    (r_bsh[WORD_BITS-1]),
        .i_m    (r_mod),
        .o_r    (res_a)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (r_mod_cfg > WORD_BITS'(1)) ? S_RED : S_DONE;
                end
            end
            S_RED: begin
                if (r_cnt == '0) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (r_exp == '0) ? S_DONE : S_MUL;
            end
            S_MUL: begin
                if (r_cnt == '0) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = (exp_next == '0) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_mod <= r_mod_cfg;
                    r_exp <= r_exp_cfg;
                    r_bsh <= i_base[WORD_BITS-1:0];
                    r_acc <= (r_mod_cfg > WORD_BITS'(1)) ? WORD_BITS'(1) : '0;
                    r_cnt <= CW'(WORD_BITS - 1);
                end
            end
            S_RED, S_MUL: begin
                r_bsh <= r_bsh << 1;
                r_cnt <= r_cnt - CW'(1);
            end
            S_LOAD: begin
                r_sq  <= res_s;
                r_bsh <= res_s;
                r_cnt <= CW'(WORD_BITS - 1);
            end
            S_UPD: begin
                if (r_exp[0]) begin
                    r_acc <= res_a;
                end
                r_sq  <= res_s;
                r_bsh <= res_s;
                r_exp <= exp_next;
                r_cnt <= CW'(WORD_BITS - 1);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_power_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out <= 64'(r_acc);
        end
    end

    `MEXP_ASSERT(a_accept_leaves_idle, in_acc |=> r_state != S_IDLE)
    `MEXP_ASSERT(a_mod_above_one, (r_state == S_MUL || r_state == S_UPD) |-> r_mod > WORD_BITS'(1))
    `MEXP_ASSERT(a_square_reduced, (r_state == S_UPD || r_state == S_LOAD) |-> res_s < r_mod)
    `MEXP_ASSERT(a_acc_reduced, r_state == S_UPD |-> res_a < r_mod)
    `MEXP_ASSERT_ALWAYS(a_stall_when_busy, (r_state != S_IDLE) |-> o_base_stall)

endmodule

// ----- hw/rtl/mexp_cell.sv -----
// ============================================================================
// mexp_cell
// One bit of a double-and-add modular multiplier row.
// ============================================================================
module mexp_cell import mexp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_clr,
    input  logic   i_step,
    input  logic   i_r_lo,
    input  logic   i_a,
    input  logic   i_b,
    input  logic   i_m,
    input  logic   i_m_lo,
    input  t_chain i_chain,
    input  t_sel   i_sel,
    output t_chain o_chain,
    output logic   o_r
);

    logic r_bit;
    logic n_bit;
    logic a_eff;
    logic s0;
    logic d1;
    logic d2;

    // The doubled residue arrives as the lower neighbor's bit.
    always_comb begin
        a_eff       = i_a & i_b;
        s0          = i_r_lo ^ a_eff ^ i_chain.c;
        o_chain.c   = (i_r_lo & a_eff) | (i_r_lo & i_chain.c) | (a_eff & i_chain.c);
        d1          = s0 ^ i_m ^ i_chain.bw1;
        o_chain.bw1 = (~s0 & i_m) | (~(s0 ^ i_m) & i_chain.bw1);
        d2          = s0 ^ i_m_lo ^ i_chain.bw2;
        o_chain.bw2 = (~s0 & i_m_lo) | (~(s0 ^ i_m_lo) & i_chain.bw2);
        case (i_sel)
            SEL_SUB2: n_bit = d2;
            SEL_SUB1: n_bit = d1;
            SEL_SUM:  n_bit = s0;
            default:  n_bit = s0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_bit <= 1'b0;
        end else if (i_step) begin
            r_bit <= n_bit;
        end
    end

    assign o_r = r_bit;

endmodule

// ----- hw/rtl/mexp_row.sv -----
// ============================================================================
// mexp_row
// Row of bit cells that forms a*b mod m one multiplier bit per cycle while i_step is high.
// ============================================================================
module mexp_row import mexp_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_clr,
    input  logic                 i_step,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic                 i_b,
    input  logic [WORD_BITS-1:0] i_m,
    output logic [WORD_BITS-1:0] o_r
);

    // Two extra cells cover 2r+a, which stays below 3m.
    localparam int N = WORD_BITS + 2;

    logic [N-1:0] a_ext;
    logic [N-1:0] m_ext;
    logic [N-1:0] r_vec;
    t_chain       chain [N+1];
    t_sel         sel;

    assign a_ext    = {2'b00, i_a};
    assign m_ext    = {2'b00, i_m};
    assign chain[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        mexp_cell u_cell (
            .i_clk   (i_clk),
            .i_clr   (i_clr),
            .i_step  (i_step),
            .i_r_lo  ((i == 0) ? 1'b0 : r_vec[(i == 0) ? 0 : i-1]),
            .i_a     (a_ext[i]),
            .i_b     (i_b),
            .i_m     (m_ext[i]),
            .i_m_lo  ((i == 0) ? 1'b0 : m_ext[(i == 0) ? 0 : i-1]),
            .i_chain (chain[i]),
            .i_sel   (sel),
            .o_chain (chain[i+1]),
            .o_r     (r_vec[i])
        );
    end

    // Keep the smallest candidate that did not go negative.
    always_comb begin
        if (!chain[N].bw2) begin
            sel = SEL_SUB2;
        end else if (!chain[N].bw1) begin
            sel = SEL_SUB1;
        end else begin
            sel = SEL_SUM;
        end
    end

    assign o_r = r_vec[WORD_BITS-1:0];

endmodule
